FILE: rtl/core/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes for the max priority queue and its cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  // key width of one entry
  localparam int KEY_W = 32;
  // width of the entry count shown on the result
  localparam int OUT_CNT_W = 7;

  // operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                    ins;
    logic                    ext;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage : bhpq_pkg

`default_nettype wire

FILE: rtl/core/bhpq_cell.sv
// ----------------------------------------------------------------------------
// bhpq_cell
// One slot of the sorted row. Holds one key, compares it against the key
// being inserted and takes its neighbor's key when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_cell
  import bhpq_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_cmd_t               cmd,
  input  wire logic                    occ,
  input  wire logic                    prev_ge,
  input  wire logic signed [KEY_W-1:0] prev_val,
  input  wire logic signed [KEY_W-1:0] next_val,
  output logic signed [KEY_W-1:0]      val,
  output logic                         ge
);

  logic signed [KEY_W-1:0] val_r;
  logic signed [KEY_W-1:0] val_nxt;

  // slot holds a key no smaller than the one coming in
  assign ge  = occ && (val_r >= cmd.key);
  assign val = val_r;

  // insert: keep, take the new key at the boundary, or shift down the row
  // extract: shift up toward the head
  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (ge) begin
        val_nxt = val_r;
      end else if (prev_ge) begin
        val_nxt = cmd.key;
      end else begin
        val_nxt = prev_val;
      end
    end else if (cmd.ext) begin
      val_nxt = next_val;
    end
  end

  // key storage, no reset: occupancy comes from the fill count
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule : bhpq_cell

`default_nettype wire

FILE: rtl/core/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max priority queue with insert and extract-max, status and entry count.
// ----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells kept sorted largest first, so the
// largest entry always sits in the head cell. For every accepted item,
// insert or extract, the whole row compares against the incoming key and
// shifts by one slot together, so busy never rises and a new item may be
// started on every clock. Each item gives exactly one result, shown with
// out_valid for one cycle on the clock after the item is taken; the
// receiver cannot stall it. An extract on an empty queue reports empty
// status and a zero value, an insert on a full queue reports full status
// and drops the key. out_entry_count shows the low seven bits of the entry
// count. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_opcode,
  input  wire logic signed [KEY_W-1:0]     in_item_value,
  output logic                             out_valid,
  output logic signed [KEY_W-1:0]          out_result_value,
  output logic [1:0]                       out_status,
  output logic                             out_is_empty,
  output logic [OUT_CNT_W-1:0]             out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                    accept;
  logic                    ins_ok;
  logic                    ext_ok;
  cell_cmd_t               cmd;
  status_t                 status;

  logic signed [KEY_W-1:0] cell_val [CAPACITY];
  logic                    cell_ge  [CAPACITY];
  logic                    cell_occ [CAPACITY];

  logic                    out_valid_r;
  logic signed [KEY_W-1:0] out_value_r;
  status_t                 out_status_r;
  logic                    out_empty_r;
  logic [OUT_CNT_W-1:0]    out_count_r;

  // the row takes an item every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // operation decode and status
  always_comb begin
    ins_ok    = 1'b0;
    ext_ok    = 1'b0;
    status    = ST_OK;
    count_nxt = count_r;
    if (accept) begin
      unique case (in_opcode)
        OP_INSERT: begin
          if (count_r == CNT_W'(CAPACITY)) begin
            status = ST_FULL;
          end else begin
            ins_ok    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_EXTRACT: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            ext_ok    = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: status = ST_OK;
      endcase
    end
  end

  assign cmd.ins = ins_ok;
  assign cmd.ext = ext_ok;
  assign cmd.key = in_item_value;

  // cell row, head cell holds the largest key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_ge;
    logic signed [KEY_W-1:0] prev_val;
    logic signed [KEY_W-1:0] next_val;

    assign cell_occ[i] = CNT_W'(i) < count_r;

    if (i == 0) begin : g_head
      assign prev_ge  = 1'b1;
      assign prev_val = cell_val[i];
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_link
      assign next_val = cell_val[i+1];
    end

    bhpq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occ      (cell_occ[i]),
      .prev_ge  (prev_ge),
      .prev_val (prev_val),
      .next_val (next_val),
      .val      (cell_val[i]),
      .ge       (cell_ge[i])
    );
  end

  // fill count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= ext_ok ? cell_val[0] : '0;
      out_status_r <= status;
      out_empty_r  <= (count_nxt == '0);
      out_count_r  <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_is_empty     = out_empty_r;
  assign out_entry_count  = out_count_r;

endmodule : binary_max_heap_priority_queue

`default_nettype wire

FILE: rtl/core/bhpq_chk.sv
// ----------------------------------------------------------------------------
// bhpq_chk
// Port-level checks for the max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_chk
  import bhpq_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    in_opcode,
  input wire logic                    out_valid,
  input wire logic signed [KEY_W-1:0] out_result_value,
  input wire logic [1:0]              out_status,
  input wire logic                    out_is_empty,
  input wire logic [OUT_CNT_W-1:0]    out_entry_count
);

  // every taken item gives a result on the next clock
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("bhpq: taken item gave no result");

  // a failed extract leaves the queue empty and returns zero
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_is_empty && out_result_value == '0))
    else $error("bhpq: empty status with entries or a value");

  // back to back results: a good insert grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && out_status == ST_OK && $past(in_opcode) == OP_INSERT)
    |-> (out_entry_count == OUT_CNT_W'($past(out_entry_count) + 1'b1)))
    else $error("bhpq: insert did not grow the count");

  // back to back results: a good extract shrinks the count by one
  a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && out_status == ST_OK && $past(in_opcode) == OP_EXTRACT)
    |-> (out_entry_count == OUT_CNT_W'($past(out_entry_count) - 1'b1)))
    else $error("bhpq: extract did not shrink the count");

endmodule : bhpq_chk

bind binary_max_heap_priority_queue bhpq_chk u_bhpq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_status       (out_status),
  .out_is_empty     (out_is_empty),
  .out_entry_count  (out_entry_count)
);

`default_nettype wire
